/* rtl/frustum_cull_tester_macros.svh */
// Assertion macros used by the frustum culling tester top level.
`ifndef FRUSTUM_CULL_TESTER_MACROS_SVH
`define FRUSTUM_CULL_TESTER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fct_pkg.sv */
// Package with the widths, function codes and command type of the frustum culling tester.
package fct_pkg;

  // Configuration of the number formats.
  localparam int COORD_WIDTH  = 32;
  localparam int NORMAL_WIDTH = 16;

  // Fixed widths of the channel fields.
  localparam int FUNC_W  = 2;
  localparam int PLANE_W = 3;
  localparam int VEC_W   = 32;
  localparam int EXT_IN_W = 31;

  // Derived number formats.
  localparam int CW    = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int EW    = ((CW - 1) < 31) ? (CW - 1) : 31;
  localparam int NFRAC = NORMAL_WIDTH - 2;

  // Plane store depth and the plane sweep.
  localparam int NUM_PLANES = 6;
  localparam int PIPE_LAT   = 2;
  localparam int CNT_W      = 3;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_PLANES - 1 + PIPE_LAT);

  // Datapath widths.
  localparam int PROD_W  = NORMAL_WIDTH + CW;
  localparam int DIST_W  = PROD_W + 3;
  localparam int RPROD_W = EW + NORMAL_WIDTH;
  localparam int R_W     = RPROD_W + 2;
  localparam int SUM_W   = DIST_W + 1;

  // Function codes of an input item.
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POINT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BOX   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CUBE  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               start;
    logic               issue;
    logic [PLANE_W-1:0] plane;
    logic               out_load;
  } fct_cmd_t;

endpackage

/* rtl/fct_channels.sv */
// Channel interfaces of the frustum culling tester: test and load items in, results out.
interface fct_in_if;
  logic                                valid;
  logic                                ready;
  logic [fct_pkg::FUNC_W-1:0]          func;
  logic [fct_pkg::PLANE_W-1:0]         plane_index;
  logic signed [fct_pkg::VEC_W-1:0]    vec_x;
  logic signed [fct_pkg::VEC_W-1:0]    vec_y;
  logic signed [fct_pkg::VEC_W-1:0]    vec_z;
  logic signed [fct_pkg::VEC_W-1:0]    plane_offset;
  logic [fct_pkg::EXT_IN_W-1:0]        ext_x;
  logic [fct_pkg::EXT_IN_W-1:0]        ext_y;
  logic [fct_pkg::EXT_IN_W-1:0]        ext_z;

  modport source (
    output valid, func, plane_index, vec_x, vec_y, vec_z, plane_offset, ext_x, ext_y, ext_z,
    input  ready
  );
  modport sink (
    input  valid, func, plane_index, vec_x, vec_y, vec_z, plane_offset, ext_x, ext_y, ext_z,
    output ready
  );
endinterface

interface fct_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

/* rtl/frustum_cull_tester.sv */
// Top level of the frustum culling tester: controller, datapath and checks.
// Six clip planes (normal Q2.14, offset Q16.16) are held in a store that reset
// clears; a load item writes one plane and a point, box or cube item is tested
// against all six, each item giving one result. A load passes through S_FIN
// before the block takes the next item; a test first passes through S_RUN,
// where one product stage visits the six planes one per cycle, and the sum
// and compare stages behind it finish before the verdict moves to the output
// register. A new item is taken while an earlier result still waits there.
`include "frustum_cull_tester_macros.svh"

module frustum_cull_tester (
  input logic      clk,
  input logic      rst_n,
  fct_in_if.sink   in_if,
  fct_out_if.source out_if
);

  fct_pkg::fct_cmd_t cmd;
  logic              in_is_load;
  logic              in_fire;

  assign in_is_load = (in_if.func == fct_pkg::FUNC_LOAD);
  assign in_fire    = in_if.valid && in_if.ready;

  // Sequencing of items and results.
  fct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_is_load (in_is_load),
    .out_ready  (out_if.ready),
    .in_ready   (in_if.ready),
    .out_valid  (out_if.valid),
    .cmd        (cmd)
  );

  // Plane store and arithmetic.
  fct_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_if.func),
    .in_plane_index  (in_if.plane_index),
    .in_vec_x        (in_if.vec_x),
    .in_vec_y        (in_if.vec_y),
    .in_vec_z        (in_if.vec_z),
    .in_plane_offset (in_if.plane_offset),
    .in_ext_x        (in_if.ext_x),
    .in_ext_y        (in_if.ext_y),
    .in_ext_z        (in_if.ext_z),
    .out_inside_res  (out_if.inside_res)
  );

  // An accepted item keeps the input closed in the following cycle.
  `FCT_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_if.ready, "input open after a transfer")

  // No plane is visited while the input is open.
  `FCT_ASSERT_NOW(a_no_issue_when_open, cmd.issue, !in_if.ready, "plane visit while input open")

  // A new result never overwrites one that has not been taken.
  `FCT_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_if.valid || out_if.ready,
                  "result overwritten before its transfer")

endmodule

/* rtl/fct_datapath.sv */
// Datapath of the frustum culling tester: plane store, product stage, sum stage and verdict.
module fct_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fct_pkg::fct_cmd_t                   cmd,
  input  logic [fct_pkg::FUNC_W-1:0]          in_func,
  input  logic [fct_pkg::PLANE_W-1:0]         in_plane_index,
  input  logic signed [fct_pkg::VEC_W-1:0]    in_vec_x,
  input  logic signed [fct_pkg::VEC_W-1:0]    in_vec_y,
  input  logic signed [fct_pkg::VEC_W-1:0]    in_vec_z,
  input  logic signed [fct_pkg::VEC_W-1:0]    in_plane_offset,
  input  logic [fct_pkg::EXT_IN_W-1:0]        in_ext_x,
  input  logic [fct_pkg::EXT_IN_W-1:0]        in_ext_y,
  input  logic [fct_pkg::EXT_IN_W-1:0]        in_ext_z,
  output logic                                out_inside_res
);

  localparam int NW = fct_pkg::NORMAL_WIDTH;
  localparam int CW = fct_pkg::CW;
  localparam int EW = fct_pkg::EW;

  // Plane store, cleared at reset.
  logic signed [NW-1:0] nrm_r [fct_pkg::NUM_PLANES][3];
  logic signed [CW-1:0] off_r [fct_pkg::NUM_PLANES];

  // Operands of the item under test.
  logic [fct_pkg::FUNC_W-1:0] func_r;
  logic signed [CW-1:0]       ctr_r [3];
  logic [EW-1:0]              ext_r [3];

  // Product stage.
  logic signed [NW-1:0]                  nsel [3];
  logic [NW-1:0]                         nmag [3];
  logic signed [fct_pkg::PROD_W-1:0]     np_nxt [3];
  logic [fct_pkg::RPROD_W-1:0]           rp_nxt [3];
  logic signed [fct_pkg::PROD_W-1:0]     np_r [3];
  logic [fct_pkg::RPROD_W-1:0]           rp_r [3];
  logic signed [CW-1:0]                  offa_r;
  logic                                  va_r;

  // Sum stage.
  logic signed [fct_pkg::DIST_W-1:0]     offs_ext;
  logic signed [fct_pkg::DIST_W-1:0]     dist_nxt;
  logic [fct_pkg::R_W-1:0]               r_nxt;
  logic signed [fct_pkg::DIST_W-1:0]     dist_r;
  logic [fct_pkg::R_W-1:0]               r_r;
  logic                                  vb_r;

  // Verdict.
  logic signed [fct_pkg::SUM_W-1:0]      dist_s;
  logic signed [fct_pkg::SUM_W-1:0]      r_s;
  logic signed [fct_pkg::SUM_W-1:0]      tot;
  logic                                  plane_ok;
  logic                                  pass_r;
  logic                                  inside_r;
  logic                                  load_hit;

  // A load writes one plane when its index names a stored plane.
  assign load_hit = cmd.start && (in_func == fct_pkg::FUNC_LOAD) &&
                    (in_plane_index < fct_pkg::PLANE_W'(fct_pkg::NUM_PLANES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < fct_pkg::NUM_PLANES; k++) begin
        for (int i = 0; i < 3; i++) begin
          nrm_r[k][i] <= '0;
        end
        off_r[k] <= '0;
      end
    end else if (load_hit) begin
      nrm_r[in_plane_index][0] <= in_vec_x[NW-1:0];
      nrm_r[in_plane_index][1] <= in_vec_y[NW-1:0];
      nrm_r[in_plane_index][2] <= in_vec_z[NW-1:0];
      off_r[in_plane_index]    <= in_plane_offset[CW-1:0];
    end
  end

  // Capture the operands on the input transfer; a cube shares one extent.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r   <= in_func;
      ctr_r[0] <= in_vec_x[CW-1:0];
      ctr_r[1] <= in_vec_y[CW-1:0];
      ctr_r[2] <= in_vec_z[CW-1:0];
      ext_r[0] <= in_ext_x[EW-1:0];
      if (in_func == fct_pkg::FUNC_CUBE) begin
        ext_r[1] <= in_ext_x[EW-1:0];
        ext_r[2] <= in_ext_x[EW-1:0];
      end else begin
        ext_r[1] <= in_ext_y[EW-1:0];
        ext_r[2] <= in_ext_z[EW-1:0];
      end
    end
  end

  // Products of the selected plane's normal with the center and the extents.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsel[i]   = nrm_r[cmd.plane][i];
      nmag[i]   = nsel[i][NW-1] ? NW'(-nsel[i]) : NW'(nsel[i]);
      np_nxt[i] = fct_pkg::PROD_W'(nsel[i]) * fct_pkg::PROD_W'(ctr_r[i]);
      rp_nxt[i] = fct_pkg::RPROD_W'(ext_r[i]) * fct_pkg::RPROD_W'(nmag[i]);
    end
  end

  always_ff @(posedge clk) begin
    np_r   <= np_nxt;
    rp_r   <= rp_nxt;
    offa_r <= off_r[cmd.plane];
  end

  // Signed distance n.p - d and the box radius.
  always_comb begin
    offs_ext = fct_pkg::DIST_W'(offa_r);
    dist_nxt = fct_pkg::DIST_W'(np_r[0]) + fct_pkg::DIST_W'(np_r[1]) +
               fct_pkg::DIST_W'(np_r[2]) - (offs_ext <<< fct_pkg::NFRAC);
    r_nxt    = fct_pkg::R_W'(rp_r[0]) + fct_pkg::R_W'(rp_r[1]) + fct_pkg::R_W'(rp_r[2]);
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    r_r    <= r_nxt;
  end

  // A point must lie strictly in front; a box may reach back by its radius.
  always_comb begin
    dist_s = fct_pkg::SUM_W'(dist_r);
    r_s    = fct_pkg::SUM_W'(r_r);
    tot    = dist_s + r_s;
    if (func_r == fct_pkg::FUNC_POINT) begin
      plane_ok = !dist_r[fct_pkg::DIST_W-1] && (|dist_r);
    end else begin
      plane_ok = !tot[fct_pkg::SUM_W-1];
    end
  end

  // Stage valids, the running verdict and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r     <= 1'b0;
      vb_r     <= 1'b0;
      pass_r   <= 1'b0;
      inside_r <= 1'b0;
    end else begin
      va_r <= cmd.issue;
      vb_r <= va_r;
      if (cmd.start) begin
        pass_r <= 1'b1;
      end else if (vb_r) begin
        pass_r <= pass_r && plane_ok;
      end
      if (cmd.out_load) begin
        inside_r <= pass_r && (func_r != fct_pkg::FUNC_LOAD);
      end
    end
  end

  assign out_inside_res = inside_r;

endmodule

/* rtl/fct_ctrl.sv */
// Controller of the frustum culling tester: accepts items, sweeps the planes, hands off results.
module fct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_is_load,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output fct_pkg::fct_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                state_r;
  logic [1:0]                state_nxt;
  logic [fct_pkg::CNT_W-1:0] cnt_r;
  logic [fct_pkg::CNT_W-1:0] cnt_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.plane = fct_pkg::PLANE_W'(cnt_r);
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = in_is_load ? S_FIN : S_RUN;
        end
      end
      S_RUN: begin
        cmd.issue = (cnt_r < fct_pkg::CNT_W'(fct_pkg::NUM_PLANES));
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == fct_pkg::LAST_CNT) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output register stays full until its transfer.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
